/* src/uwee_pkg.sv */
package uwee_pkg;

   // defaults for the top-level parameters
   localparam int MEM_BITS_DEF   = 1024;
   localparam int DATA_WIDTH_DEF = 16;
   localparam int ADDR_WIDTH_DEF = 6;

   // input bit counter, saturating
   localparam int              TAKEN_W   = 6;
   localparam logic [TAKEN_W-1:0] TAKEN_MAX = 6'd63;

   // start bit plus 2-bit opcode
   localparam logic [2:0] OP_EXT   = 3'd4;
   localparam logic [2:0] OP_WRITE = 3'd5;
   localparam logic [2:0] OP_READ  = 3'd6;
   localparam logic [2:0] OP_ERASE = 3'd7;

   // sub-codes of the extended opcode
   localparam logic [1:0] SUB_EWDS = 2'd0;
   localparam logic [1:0] SUB_EWEN = 2'd3;

   typedef struct packed {
      logic capture;   // latch the request fields
      logic step;      // apply one item to the protocol state
      logic load;      // finish an item that read the memory
   } uwee_cmd_type;

   typedef struct packed {
      logic need_load; // the stepped item still needs the memory read data
   } uwee_sts_type;

endpackage

/* src/uwee_mem.sv */
module uwee_mem #(
   parameter int WORDS      = 64,
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [$clog2(WORDS)-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0]        wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(WORDS)-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0]        rd_data
);
   logic [DATA_WIDTH-1:0] store_mem [WORDS];
   logic [WORDS-1:0]      valid_ff;
   logic [WORDS-1:0]      valid_in;
   logic [DATA_WIDTH-1:0] rd_word_ff;
   logic                  rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff  <= store_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // entries never written since reset read as zero
   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

/* src/uwee_ctrl.sv */
module uwee_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output uwee_pkg::uwee_cmd_type cmd,
   input  uwee_pkg::uwee_sts_type sts,
   output logic                  rsp_valid
);
   import uwee_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EVAL = 3'b010,
      ST_LOAD = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.step = 1'b1;
            if (sts.need_load) begin
               state_in = ST_LOAD;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_LOAD: begin
            cmd.load     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_rsp_in_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("response strobe outside idle");

   a_load_after_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> ($past(state_ff) == ST_EVAL))
      else $error("load state not entered from eval");

   a_accept_to_eval: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_EVAL))
      else $error("accepted item not evaluated");

   a_eval_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) |=> (rsp_valid_ff || state_ff == ST_LOAD))
      else $error("evaluated item without response or load");

endmodule

/* src/uwee_dp.sv */
module uwee_dp #(
   parameter int MEM_BITS   = uwee_pkg::MEM_BITS_DEF,
   parameter int DATA_WIDTH = uwee_pkg::DATA_WIDTH_DEF,
   parameter int ADDR_WIDTH = uwee_pkg::ADDR_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  uwee_pkg::uwee_cmd_type cmd,
   output uwee_pkg::uwee_sts_type sts,
   input  logic                   req_func,
   input  logic                   req_sk,
   input  logic                   req_cs,
   input  logic                   req_di,
   input  logic [6:0]             req_fill_offset,
   input  logic [7:0]             req_fill_byte,
   output logic                   rsp_data_out
);
   import uwee_pkg::*;

   localparam int WORDS   = MEM_BITS / DATA_WIDTH;
   localparam int BYTES   = MEM_BITS / 8;
   localparam int IDX_W   = $clog2(WORDS);
   localparam int IN_BITS = ADDR_WIDTH + DATA_WIDTH + 3;
   localparam int SEND_W  = $clog2(DATA_WIDTH + 2);
   localparam int CMP_W   = (ADDR_WIDTH > IDX_W + 1) ? ADDR_WIDTH : IDX_W + 1;
   localparam int OP_W    = DATA_WIDTH + 3;

   localparam logic [CMP_W-1:0]   WORD_MASK  = CMP_W'(WORDS - 1);
   localparam logic [CMP_W-1:0]   WORD_COUNT = CMP_W'(WORDS);
   localparam logic [TAKEN_W-1:0] TAKEN_FULL = TAKEN_W'(IN_BITS);
   localparam logic [TAKEN_W-1:0] TAKEN_CMD  = TAKEN_W'(ADDR_WIDTH + 3);
   localparam logic [SEND_W-1:0]  SEND_READ  = SEND_W'(DATA_WIDTH);

   // latched request fields
   logic       func_ff, sk_ff, cs_ff, di_ff;
   logic [6:0] off_ff;
   logic [7:0] byte_ff;

   // protocol state
   logic                  last_clock_ff, last_clock_in;
   logic                  out_bit_ff, out_bit_in;
   logic                  we_ff, we_in;
   logic [IN_BITS-1:0]    shift_in_ff, shift_in_in;
   logic [TAKEN_W-1:0]    taken_ff, taken_in;
   logic [SEND_W-1:0]     send_ff, send_in;
   logic [DATA_WIDTH:0]   shift_out_ff, shift_out_in;

   // remember whether the read address was in range
   logic                  cmd_addr_hold_ff, cmd_addr_hold_in;

   // memory port
   logic                  mem_wr_en, mem_rd_en;
   logic [IDX_W-1:0]      mem_wr_addr, mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data, mem_rd_data;

   // edge decode
   logic [TAKEN_W-1:0]    taken_new;
   logic [IN_BITS-1:0]    shift_new;
   logic [OP_W-1:0]       cmd_op;
   logic [1:0]            cmd_sub;
   logic [CMP_W-1:0]      cmd_masked, wr_masked;
   logic                  cmd_addr_ok, wr_addr_ok;
   logic                  rise;

   // fill decode
   logic                  fill_ok;
   logic [IDX_W-1:0]      fill_idx;
   logic [15:0]           fill_old;
   logic [15:0]           fill_merged;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         sk_ff   <= req_sk;
         cs_ff   <= req_cs;
         di_ff   <= req_di;
         off_ff  <= req_fill_offset;
         byte_ff <= req_fill_byte;
      end
   end

   always_comb begin
      fill_ok  = 1'b0;
      fill_idx = '0;
      if (DATA_WIDTH > 8) begin
         fill_ok  = ((BYTES > 127) || (off_ff < 7'(BYTES)))
                 && ((WORDS > 63) || (off_ff[6:1] < 6'(WORDS)));
         fill_idx = IDX_W'(off_ff[6:1]);
      end else begin
         fill_ok  = (WORDS > 127) || (off_ff < 7'(WORDS));
         fill_idx = IDX_W'(off_ff);
      end
      fill_old = 16'(mem_rd_data);
      if (DATA_WIDTH > 8) begin
         fill_merged = off_ff[0] ? {byte_ff, fill_old[7:0]} : {fill_old[15:8], byte_ff};
      end else begin
         fill_merged = {8'h00, byte_ff};
      end
   end

   always_comb begin
      rise      = sk_ff && !last_clock_ff;
      taken_new = taken_ff;
      if (di_ff && (shift_in_ff == '0)) begin
         taken_new = TAKEN_W'(1);
      end else if (taken_ff < TAKEN_MAX) begin
         taken_new = taken_ff + TAKEN_W'(1);
      end
      shift_new   = {shift_in_ff[IN_BITS-2:0], di_ff};
      cmd_op      = shift_new[IN_BITS-1:ADDR_WIDTH];
      cmd_sub     = shift_new[ADDR_WIDTH-1:ADDR_WIDTH-2];
      cmd_masked  = CMP_W'(shift_new[ADDR_WIDTH-1:0]) & WORD_MASK;
      cmd_addr_ok = cmd_masked < WORD_COUNT;
      wr_masked   = CMP_W'(shift_new[DATA_WIDTH+ADDR_WIDTH-1:DATA_WIDTH]) & WORD_MASK;
      wr_addr_ok  = wr_masked < WORD_COUNT;
   end

   always_comb begin
      last_clock_in = last_clock_ff;
      out_bit_in    = out_bit_ff;
      we_in         = we_ff;
      shift_in_in   = shift_in_ff;
      taken_in      = taken_ff;
      send_in       = send_ff;
      shift_out_in  = shift_out_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;
      sts.need_load = 1'b0;

      if (cmd.step) begin
         if (func_ff) begin
            // preload: read the word, merge the byte in the next cycle
            mem_rd_en     = fill_ok;
            mem_rd_addr   = fill_idx;
            sts.need_load = fill_ok;
         end else if (!cs_ff) begin
            send_in       = '0;
            taken_in      = '0;
            shift_in_in   = '0;
            out_bit_in    = 1'b1;
            last_clock_in = sk_ff;
         end else begin
            last_clock_in = sk_ff;
            if (rise) begin
               if (send_ff == '0) begin
                  taken_in    = taken_new;
                  shift_in_in = shift_new;
                  out_bit_in  = 1'b1;
                  if (taken_new == TAKEN_FULL) begin
                     if ((shift_new[IN_BITS-1:IN_BITS-3] == OP_WRITE) && we_ff
                         && wr_addr_ok) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = wr_masked[IDX_W-1:0];
                        mem_wr_data = shift_new[DATA_WIDTH-1:0];
                     end
                  end else if (taken_new == TAKEN_CMD) begin
                     if (cmd_op == OP_W'(OP_EXT)) begin
                        if (cmd_sub == SUB_EWDS) begin
                           we_in = 1'b0;
                        end else if (cmd_sub == SUB_EWEN) begin
                           we_in = 1'b1;
                        end
                     end else if (cmd_op == OP_W'(OP_READ)) begin
                        // dummy zero goes out now, data follows from the load
                        send_in       = SEND_READ;
                        out_bit_in    = 1'b0;
                        mem_rd_en     = cmd_addr_ok;
                        mem_rd_addr   = cmd_masked[IDX_W-1:0];
                        sts.need_load = 1'b1;
                     end else if (cmd_op == OP_W'(OP_ERASE)) begin
                        if (we_ff && cmd_addr_ok) begin
                           mem_wr_en   = 1'b1;
                           mem_wr_addr = cmd_masked[IDX_W-1:0];
                           mem_wr_data = '1;
                        end
                     end
                  end
               end else begin
                  send_in      = send_ff - SEND_W'(1);
                  out_bit_in   = shift_out_ff[DATA_WIDTH];
                  shift_out_in = {shift_out_ff[DATA_WIDTH-1:0], 1'b0};
               end
            end
         end
      end

      if (cmd.load) begin
         if (func_ff) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = fill_idx;
            mem_wr_data = DATA_WIDTH'(fill_merged);
         end else begin
            // out-of-range read address: the register read was skipped, use zero
            shift_out_in = {(cmd_addr_hold_ff ? mem_rd_data : '0), 1'b0};
         end
      end
   end

   assign cmd_addr_hold_in = (cmd.step && sts.need_load) ? (func_ff || cmd_addr_ok)
                                                         : cmd_addr_hold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_clock_ff    <= 1'b0;
         out_bit_ff       <= 1'b1;
         we_ff            <= 1'b0;
         shift_in_ff      <= '0;
         taken_ff         <= '0;
         send_ff          <= '0;
         shift_out_ff     <= '0;
         cmd_addr_hold_ff <= 1'b0;
      end else begin
         last_clock_ff    <= last_clock_in;
         out_bit_ff       <= out_bit_in;
         we_ff            <= we_in;
         shift_in_ff      <= shift_in_in;
         taken_ff         <= taken_in;
         send_ff          <= send_in;
         shift_out_ff     <= shift_out_in;
         cmd_addr_hold_ff <= cmd_addr_hold_in;
      end
   end

   uwee_mem #(
      .WORDS      (WORDS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_data_out = out_bit_ff;

   a_no_write_on_load_read: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && !func_ff) |-> !mem_wr_en)
      else $error("memory written while loading read data");

   a_read_starts_low: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && !func_ff && sts.need_load) |=> (!out_bit_ff && send_ff == SEND_READ))
      else $error("read command did not send the dummy zero");

   a_send_bounded: assert property (@(posedge clock) disable iff (reset)
      send_ff <= SEND_READ)
      else $error("send counter beyond data width");

endmodule

/* src/microwire_serial_eeprom_top.sv */
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+------------------------------
// request   | req_func req_sk req_cs req_di           | taken when start & !busy
//           | req_fill_offset req_fill_byte           |
// response  | rsp_data_out                            | rsp_valid, one cycle each
//
// An item goes from accept through ST_EVAL to the response strobe; a READ command and a
// preload also go through ST_LOAD, for the registered read port of the word memory.
// A new item can be accepted in the same cycle the previous response is strobed.
// Synchronous active-high reset clears the protocol state and all memory valid bits,
// so the memory reads as zero until written; no clearing pass is needed.
// The response side has no stall: each response is strobed exactly once.
module microwire_serial_eeprom_top #(
   parameter int MEM_BITS   = uwee_pkg::MEM_BITS_DEF,
   parameter int DATA_WIDTH = uwee_pkg::DATA_WIDTH_DEF,
   parameter int ADDR_WIDTH = uwee_pkg::ADDR_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_func,
   input  logic       req_sk,
   input  logic       req_cs,
   input  logic       req_di,
   input  logic [6:0] req_fill_offset,
   input  logic [7:0] req_fill_byte,
   output logic       rsp_valid,
   output logic       rsp_data_out
);
   import uwee_pkg::*;

   uwee_cmd_type cmd;
   uwee_sts_type sts;

   uwee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid)
   );

   uwee_dp #(
      .MEM_BITS   (MEM_BITS),
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_sk          (req_sk),
      .req_cs          (req_cs),
      .req_di          (req_di),
      .req_fill_offset (req_fill_offset),
      .req_fill_byte   (req_fill_byte),
      .rsp_data_out    (rsp_data_out)
   );

endmodule
